[hdl/assert_macros.svh]
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every rising edge of clk once reset is low.
`define SIST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that cond in one cycle is followed by nxt in the next cycle.
`define SIST_ASSERT_NEXT(lbl, cond, nxt, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) else $error(msg);

`endif

[hdl/sist_pkg.sv]
// Shared types and constants of the sorted insert and search table.
package sist_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int MAX_CAPACITY = 1024;
  localparam int POS_W        = $clog2(MAX_CAPACITY + 1);
  localparam int OUT_W        = 5;
  localparam int VAL_W        = 32;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  // Word travelling down the cell chain.
  typedef struct packed {
    logic                    active;
    logic                    cmd;
    logic                    done;
    logic                    placed;
    logic                    found;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] value;
  } token_t;

endpackage

[hdl/sist_cell.sv]
// One table slot: holds an entry and handles the word passing through it.
module sist_cell #(
  parameter int CAPACITY = sist_pkg::DEF_CAPACITY,
  parameter int IDX      = 0,
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [CW-1:0]   count,
  input  sist_pkg::token_t tin,
  output sist_pkg::token_t tout
);
  import sist_pkg::*;

  logic signed [VAL_W-1:0] entry;
  logic signed [VAL_W-1:0] entry_next;
  logic                    entry_we;
  logic                    slot_valid;
  token_t                  tout_next;

  assign slot_valid = count > CW'(IDX);

  always_comb begin
    tout_next  = tin;
    entry_next = tin.value;
    entry_we   = 1'b0;
    if (tin.active && !tin.done) begin
      if (tin.cmd == CMD_INSERT) begin
        if (!slot_valid) begin
          // first free slot: drop the word here
          entry_we         = 1'b1;
          tout_next.done   = 1'b1;
          tout_next.placed = 1'b1;
        end else if (!(entry < tin.value)) begin
          // swap: keep the smaller word, push the old entry up
          entry_we        = 1'b1;
          tout_next.value = entry;
        end
      end else begin
        if (!slot_valid || entry > tin.value) begin
          tout_next.done = 1'b1;
        end else if (entry == tin.value) begin
          tout_next.done  = 1'b1;
          tout_next.found = 1'b1;
          tout_next.pos   = POS_W'(IDX + 1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (entry_we) begin
      entry <= entry_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tout.active <= 1'b0;
    end else begin
      tout.active <= tout_next.active;
    end
    tout.cmd    <= tout_next.cmd;
    tout.done   <= tout_next.done;
    tout.placed <= tout_next.placed;
    tout.found  <= tout_next.found;
    tout.pos    <= tout_next.pos;
    tout.value  <= tout_next.value;
  end

endmodule

[hdl/sorted_insert_search_table.sv]
// Top level of the sorted insert and search table: a chain of slot cells.
// A word is taken only while busy is low; it raises busy and walks the cell
// chain one slot per cycle. The result strobe (done) rises when it leaves the
// last slot, and busy drops at the edge that takes the result, so a new word
// is taken only after the result of the last one.
// The result cannot be stalled. Reset (rst, synchronous): table empty,
// chain drained, busy low.
module sorted_insert_search_table #(
  parameter int CAPACITY = sist_pkg::DEF_CAPACITY
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              cmd,
  input  logic signed [sist_pkg::VAL_W-1:0] value,
  output logic                              done,
  output logic                              accepted,
  output logic                              found,
  output logic [sist_pkg::OUT_W-1:0]        position,
  output logic [sist_pkg::OUT_W-1:0]        entry_count
);
  import sist_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          busy_next;
  logic          launch;
  token_t        chain [CAPACITY+1];

  // Accept a word only when no word is walking the chain.
  assign launch = start && !busy;

  // Build the word entering slot 0. A full table marks an insert as
  // finished before it starts, so no slot takes it.
  always_comb begin
    chain[0]        = '0;
    chain[0].active = launch;
    chain[0].cmd    = cmd;
    chain[0].value  = value;
    chain[0].done   = (cmd == CMD_INSERT) && (count == CW'(CAPACITY));
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sist_cell #(
      .CAPACITY(CAPACITY),
      .IDX     (i),
      .CW      (CW)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .count(count),
      .tin  (chain[i]),
      .tout (chain[i+1])
    );
  end

  // The word leaving the last slot is the result.
  assign done        = chain[CAPACITY].active;
  assign accepted    = chain[CAPACITY].placed;
  assign found       = chain[CAPACITY].found;
  assign position    = OUT_W'(chain[CAPACITY].pos);
  assign entry_count = OUT_W'(count_next);

  always_comb begin
    count_next = count;
    if (done && chain[CAPACITY].placed) begin
      count_next = count + CW'(1);
    end
  end

  always_comb begin
    busy_next = busy;
    if (launch) begin
      busy_next = 1'b1;
    end else if (done) begin
      busy_next = 1'b0;
    end
  end

  // Hold count steady while a word walks the chain; advance it at the end.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      busy  <= 1'b0;
    end else begin
      count <= count_next;
      busy  <= busy_next;
    end
  end

endmodule

[hdl/sist_checker.sv]
// Port-level checks of the sorted insert and search table, with its bind.
`include "assert_macros.svh"

module sist_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic                              done,
  input logic                              accepted,
  input logic                              found,
  input logic [sist_pkg::OUT_W-1:0]        position
);
  import sist_pkg::*;

  `SIST_ASSERT(a_done_busy, done |-> busy, "result strobe without a word in flight")
  `SIST_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted word did not raise busy")
  `SIST_ASSERT_NEXT(a_one_result, done, !done && !busy, "result strobe held or busy stuck")
  `SIST_ASSERT(a_pos_found, done && !found |-> position == '0, "position without a match")
  `SIST_ASSERT(a_excl, done |-> !(found && accepted), "insert and match flagged together")

endmodule

bind sorted_insert_search_table sist_checker u_sist_checker (.*);

[tb/sorted_insert_search_table_checker.sv]
// Checker for the sorted insert and search table: predicts each result and compares it.
module sorted_insert_search_table_checker #(
  parameter int CAPACITY = sist_pkg::DEF_CAPACITY
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              busy,
  input  logic                              cmd,
  input  logic signed [sist_pkg::VAL_W-1:0] value,
  input  logic                              done,
  input  logic                              accepted,
  input  logic                              found,
  input  logic [sist_pkg::OUT_W-1:0]        position,
  input  logic [sist_pkg::OUT_W-1:0]        entry_count,
  output int                                mismatches,
  output int                                pending,
  output int                                hits,
  output int                                rejects
);
  timeunit 1ns;
  timeprecision 1ps;
  import sist_pkg::*;

  typedef struct packed {
    logic             accepted;
    logic             found;
    logic [OUT_W-1:0] position;
    logic [OUT_W-1:0] entry_count;
  } table_result_t;

  // Shadow copy of the table, ascending.
  logic signed [VAL_W-1:0] shadow_vals [CAPACITY];
  int                      shadow_count = 0;
  table_result_t           expected_results [$];
  int                      mismatch_count = 0;
  int                      hit_count = 0;
  int                      reject_count = 0;
  int                      result_seq = 0;

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 60) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic check_field(string field, int unsigned got, int unsigned want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                result_seq, field, got, want));
  endtask

  // Apply one word to the shadow table and return the result it should give.
  function automatic table_result_t apply_word(logic op, logic signed [VAL_W-1:0] v);
    table_result_t r;
    int            slot;
    int            i;
    r = '0;
    if (op == CMD_INSERT) begin
      if (shadow_count < CAPACITY) begin
        slot = 0;
        while (slot < shadow_count && shadow_vals[slot] < v) slot++;
        for (i = shadow_count; i > slot; i--) shadow_vals[i] = shadow_vals[i-1];
        shadow_vals[slot] = v;
        shadow_count++;
        r.accepted = 1'b1;
      end
    end else begin
      for (i = 0; i < shadow_count; i++) begin
        if (shadow_vals[i] == v) begin
          r.found    = 1'b1;
          r.position = OUT_W'(i + 1);
          break;
        end
        if (shadow_vals[i] > v) break;
      end
    end
    r.entry_count = OUT_W'(shadow_count);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    table_result_t want;
    if (rst) begin
      shadow_count = 0;
      expected_results.delete();
    end else begin
      // Compare first: a word accepted at this edge cannot finish at it.
      if (done) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no word waiting", result_seq));
        end else begin
          want = expected_results.pop_front();
          check_field("accepted", accepted, want.accepted);
          check_field("found", found, want.found);
          check_field("position", position, want.position);
          check_field("entry_count", entry_count, want.entry_count);
        end
        result_seq++;
      end
      if (start && !busy) begin
        want = apply_word(cmd, value);
        if (want.found) hit_count++;
        if (cmd == CMD_INSERT && !want.accepted) reject_count++;
        expected_results.push_back(want);
      end
    end
    mismatches <= mismatch_count;
    pending    <= expected_results.size();
    hits       <= hit_count;
    rejects    <= reject_count;
  end

endmodule

[tb/sorted_insert_search_table_tb.sv]
// Top of the sorted insert and search table testbench: stimulus, watchdog and verdict.
module sorted_insert_search_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sist_pkg::*;

  localparam int CAPACITY     = DEF_CAPACITY;
  localparam int RANDOM_WORDS = 1000;
  localparam int PHASES       = 4;
  // A word's walk down the chain and the longest sender gap are both far
  // shorter than this, so a quiet stretch this long means the block is hung.
  localparam int QUIET_LIMIT  = 2000;

  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  logic                    clk   = 1'b0;
  logic                    rst   = 1'b1;
  logic                    start = 1'b0;
  logic                    cmd   = CMD_INSERT;
  logic signed [VAL_W-1:0] value = '0;
  logic                    busy;
  logic                    done;
  logic                    accepted;
  logic                    found;
  logic [OUT_W-1:0]        position;
  logic [OUT_W-1:0]        entry_count;

  int mismatches;
  int pending;
  int hits;
  int rejects;

  // Values sent as inserts, used to aim searches and duplicates at the table.
  logic signed [VAL_W-1:0] inserted_vals [$];
  int                      insert_words = 0;
  int                      search_words = 0;

  // Sender pacing per phase, as percent of words preceded by a gap. The
  // third phase is the receiver-stall phase; results cannot be held off,
  // so it runs unpaced like the first.
  int idle_pcts [PHASES] = '{0, 56, 0, 35};

  sorted_insert_search_table #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .value      (value),
    .done       (done),
    .accepted   (accepted),
    .found      (found),
    .position   (position),
    .entry_count(entry_count)
  );

  sorted_insert_search_table_checker #(
    .CAPACITY(CAPACITY)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .value      (value),
    .done       (done),
    .accepted   (accepted),
    .found      (found),
    .position   (position),
    .entry_count(entry_count),
    .mismatches (mismatches),
    .pending    (pending),
    .hits       (hits),
    .rejects    (rejects)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Offer one word and hold it until the block takes it. With idle_pct
  // percent probability, drop start for a random gap first; otherwise keep
  // start high so back-to-back words never toggle it within one step.
  task automatic send_word(logic op, logic signed [VAL_W-1:0] v, int idle_pct);
    int gap;
    gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 40) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= op;
    value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    // The word was taken at this edge.
    if (op == CMD_INSERT) begin
      insert_words++;
      inserted_vals.push_back(v);
    end else begin
      search_words++;
    end
  endtask

  // Hold the sender off until every outstanding result has come back.
  task automatic drain_results();
    start <= 1'b0;
    // Skip one edge so pending already counts the last accepted word.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Pick a value: extremes, a tight cluster around zero that makes equal
  // values likely, values already sent and their neighbors, or anything.
  function automatic logic signed [VAL_W-1:0] pick_value();
    logic signed [VAL_W-1:0] v;
    int                      n;
    n = inserted_vals.size();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       v = VAL_MIN;
          1:       v = VAL_MAX;
          2:       v = '0;
          default: v = -1;
        endcase
      end
      1, 2: v = $signed($urandom_range(0, 15)) - 8;
      3, 4, 5: v = (n > 0) ? inserted_vals[$urandom_range(0, n - 1)] : $urandom();
      6: begin
        v = (n > 0) ? inserted_vals[$urandom_range(0, n - 1)] : '0;
        v = $urandom_range(0, 1) ? v + 1 : v - 1;
      end
      default: v = $urandom();
    endcase
    return v;
  endfunction

  initial begin : stimulus
    int phase;
    int k;
    logic op;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Search an empty table first.
    send_word(CMD_SEARCH, 32'sd0, 0);
    // Insert the extremes, zero and its neighbors, then equal values at
    // the low end and in the middle so the new one lands before its twins.
    send_word(CMD_INSERT, 32'sd0, 0);
    send_word(CMD_INSERT, VAL_MIN, 0);
    send_word(CMD_INSERT, VAL_MAX, 0);
    send_word(CMD_INSERT, -32'sd1, 0);
    send_word(CMD_INSERT, 32'sd1, 0);
    send_word(CMD_INSERT, 32'sd0, 0);
    send_word(CMD_INSERT, VAL_MIN, 0);
    // Hit the first and last slots, the first of a duplicate run, and miss
    // just inside the stored range.
    send_word(CMD_SEARCH, VAL_MIN, 0);
    send_word(CMD_SEARCH, VAL_MAX, 0);
    send_word(CMD_SEARCH, 32'sd0, 0);
    send_word(CMD_SEARCH, 32'sd2, 0);
    send_word(CMD_SEARCH, -32'sd2, 0);
    // Fill the table with alternating bit patterns and random values.
    send_word(CMD_INSERT, 32'sh5555_5555, 0);
    send_word(CMD_INSERT, 32'shAAAA_AAAA, 0);
    repeat (7) send_word(CMD_INSERT, $urandom(), 0);
    // Table full: the insert is rejected and nothing moves.
    send_word(CMD_INSERT, 32'sd3, 0);
    send_word(CMD_SEARCH, VAL_MAX, 0);
    send_word(CMD_SEARCH, VAL_MIN, 0);
    drain_results();

    // Random part, one pacing setting per phase, draining between phases.
    for (phase = 0; phase < PHASES; phase++) begin
      for (k = 0; k < RANDOM_WORDS / PHASES; k++) begin
        op = ($urandom_range(0, 99) < 40) ? CMD_INSERT : CMD_SEARCH;
        send_word(op, pick_value(), idle_pcts[phase]);
      end
      drain_results();
    end

    // Let any stray result show up before the verdict.
    repeat (4 * CAPACITY) @(posedge clk);

    $display("Covered %0d inserts (%0d rejected on a full table) and %0d searches (%0d hits),",
             insert_words, rejects, search_words, hits);
    $display("over a directed fill and %0d paced phases of random words.", PHASES);
    if (mismatches == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: count cycles in which neither a word nor a result moves.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    wait (!rst);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || done) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Timeout: no word or result moved for %0d cycles", QUIET_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/sist_pkg.sv
hdl/sist_cell.sv
hdl/sorted_insert_search_table.sv
hdl/sist_checker.sv
tb/sorted_insert_search_table_checker.sv
tb/sorted_insert_search_table_tb.sv
